[rtl/srle_pkg.sv]
// ----------------------------------------------------------------------------
// Sprite row RLE package
// Shared constants, codes and types of the sprite row run-length encoder.
// ----------------------------------------------------------------------------
package srle_pkg;

   localparam int MAX_WIDTH = 128;
   localparam int COL_AW    = $clog2(MAX_WIDTH);
   localparam logic [7:0] RUN_CAP = 8'd255;

   localparam logic [7:0] WIDTH_RESET  = 8'd16;
   localparam logic [7:0] HEIGHT_RESET = 8'd16;

   typedef enum logic {
      CSR_SPRITE_WIDTH  = 1'b0,
      CSR_SPRITE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CNT,
      S_COL,
      S_GAP,
      S_PUT,
      S_FLUSH
   } state_type;

   typedef enum logic {
      PH_KIND,
      PH_ROW
   } phase_type;

   // One step of the bit packer: eight bits (wide) or two bits, or a flush.
   typedef struct packed {
      logic       step;
      logic       wide;
      logic [7:0] bits;
      logic       flush;
      logic       last;
   } pack_req_type;

endpackage

[rtl/srle_ifs.sv]
// ----------------------------------------------------------------------------
// Sprite row RLE channel interfaces
// Valid/ready channels for pixels in and encoded bytes out.
// ----------------------------------------------------------------------------
interface srle_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink (input valid, input pixel, output ready);
endinterface

interface srle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       image_done;

   modport source (output valid, output out_byte, output image_done, input ready);
   modport sink (input valid, input out_byte, input image_done, output ready);
endinterface

[rtl/sprite_row_run_length_encoder_unit.sv]
// ----------------------------------------------------------------------------
// Sprite row run-length encoder
// Codes sprite rows as alternating transparent and opaque runs, each an
// 8-bit count with the 2-bit colours of opaque runs, packed MSB first.
// ----------------------------------------------------------------------------
// A pixel that extends the current run only adds to it; one that closes a run
// first sends the run's count, the colours of a closed opaque run and, after a
// capped run, an empty run. A row end sends its last run; an image end then flushes.
// Each code step waits while the output register holds an untaken byte; a byte is
// visible on rsp in the cycle after the step that completes it. Synchronous reset gives
// an empty image and size registers of 16; the colour store keeps its contents.
module sprite_row_run_length_encoder_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  srle_pkg::csr_index_type csr_index,
   input  logic [7:0]              csr_wdata,
   srle_req_if.sink                req_chan,
   srle_rsp_if.source              rsp_chan
);

   localparam int AW = srle_pkg::COL_AW;

   // Controller to colour store.
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [1:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [1:0]    ram_rdata;

   // Controller to packer: one code step per cycle when the output slot is
   // free.
   srle_pkg::pack_req_type pack_req;
   logic                   slot_free;

   // The controller owns run state and the pixel transaction handshake.
   srle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .in_valid  (req_chan.valid),
      .in_pixel  (req_chan.pixel),
      .in_ready  (req_chan.ready),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .pack_req  (pack_req),
      .slot_free (slot_free)
   );

   // Colours of the open opaque run, indexed by position within the run.
   srle_colour_ram u_colour_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // The packer holds the output register, so the result transaction can
   // wait while the controller keeps taking pixels that extend the open run.
   srle_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .pack_req  (pack_req),
      .slot_free (slot_free),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_byte  (rsp_chan.out_byte),
      .rsp_done  (rsp_chan.image_done)
   );

`ifndef SYNTHESIS
   // No code bits are produced in the cycle a pixel is taken.
   a_accept_no_pack: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> !pack_req.step)
      else $error("pack step during pixel transaction");

   // Colour writes never overlap a run being read out.
   a_write_no_pack: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> !pack_req.step)
      else $error("colour write during code step");

   // A completed flush returns the block to accepting pixels.
   a_flush_idle: assert property (@(posedge clock) disable iff (reset)
      (pack_req.step && pack_req.flush && slot_free) |=> req_chan.ready)
      else $error("not ready after image flush");
`endif

endmodule

[rtl/srle_colour_ram.sv]
// ----------------------------------------------------------------------------
// Sprite row RLE colour store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module srle_colour_ram (
   input  logic                       clock,
   input  logic                       we,
   input  logic [srle_pkg::COL_AW-1:0] waddr,
   input  logic [1:0]                 wdata,
   input  logic [srle_pkg::COL_AW-1:0] raddr,
   output logic [1:0]                 rdata
);

   logic [1:0] colour_mem [srle_pkg::MAX_WIDTH];
   logic [1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         colour_mem[waddr] <= wdata;
      end
      rdata_ff <= colour_mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/srle_packer.sv]
// ----------------------------------------------------------------------------
// Sprite row RLE bit packer
// Collects code bits MSB first and loads finished bytes into the output
// register.
// ----------------------------------------------------------------------------
module srle_packer (
   input  logic                   clock,
   input  logic                   reset,
   input  srle_pkg::pack_req_type pack_req,
   output logic                   slot_free,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_byte,
   output logic                   rsp_done
);

   logic [6:0] acc_ff, acc_in;
   logic [2:0] held_ff, held_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       done_ff, done_in;

   logic [15:0] cat;
   logic [3:0]  total;
   logic [3:0]  excess;
   logic        emit;
   logic [7:0]  word;
   logic        take;

   assign slot_free = !valid_ff || rsp_ready;
   assign take      = pack_req.step && slot_free;

   always_comb begin
      if (pack_req.wide) begin
         cat   = (16'(acc_ff) << 8) | 16'(pack_req.bits);
         total = 4'(held_ff) + 4'd8;
      end else begin
         cat   = (16'(acc_ff) << 2) | 16'(pack_req.bits[1:0]);
         total = 4'(held_ff) + 4'd2;
      end
      excess = total - 4'd8;

      acc_in  = acc_ff;
      held_in = held_ff;
      emit    = 1'b0;
      word    = 8'(cat >> excess[2:0]);

      if (pack_req.flush) begin
         // Leftover bits go out left-aligned.
         emit    = held_ff != 3'd0;
         word    = 8'(16'(acc_ff) << (4'd8 - 4'(held_ff)));
         acc_in  = '0;
         held_in = '0;
      end else if (total >= 4'd8) begin
         emit    = 1'b1;
         acc_in  = cat[6:0];
         held_in = excess[2:0];
      end else begin
         acc_in  = cat[6:0];
         held_in = total[2:0];
      end

      valid_in = valid_ff;
      byte_in  = byte_ff;
      done_in  = done_ff;
      if (take && emit) begin
         valid_in = 1'b1;
         byte_in  = word;
         done_in  = pack_req.flush || (pack_req.last && excess == 4'd0);
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         held_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (take) begin
            acc_ff  <= acc_in;
            held_ff <= held_in;
         end
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      done_ff <= done_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_byte  = byte_ff;
   assign rsp_done  = done_ff;

endmodule

[rtl/srle_ctrl.sv]
// ----------------------------------------------------------------------------
// Sprite row RLE controller
// Tracks runs, columns and rows, keeps the colour store and sequences the
// code bits of each closed run into the packer.
// ----------------------------------------------------------------------------
module srle_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  srle_pkg::csr_index_type     csr_index,
   input  logic [7:0]                  csr_wdata,
   input  logic                        in_valid,
   input  logic [2:0]                  in_pixel,
   output logic                        in_ready,
   output logic                        ram_we,
   output logic [srle_pkg::COL_AW-1:0] ram_waddr,
   output logic [1:0]                  ram_wdata,
   output logic [srle_pkg::COL_AW-1:0] ram_raddr,
   input  logic [1:0]                  ram_rdata,
   output srle_pkg::pack_req_type      pack_req,
   input  logic                        slot_free
);

   localparam int AW = srle_pkg::COL_AW;

   srle_pkg::state_type state_ff, state_in;
   srle_pkg::phase_type phase_ff, phase_in;
   logic          mode_ff, mode_in;
   logic [7:0]    len_ff, len_in;
   logic [7:0]    col_ff, col_in;
   logic [7:0]    row_ff, row_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [2:0]    pix_ff, pix_in;
   logic [7:0]    width_ff, height_ff;

   logic [7:0] w_eff;
   logic [7:0] h_eff;
   logic [2:0] put_pix;
   logic       row_end;
   logic       image_end;
   logic       do_put;
   logic       close_done;
   logic       in_kind;
   logic       pix_kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= srle_pkg::WIDTH_RESET;
         height_ff <= srle_pkg::HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            srle_pkg::CSR_SPRITE_WIDTH:  width_ff  <= csr_wdata;
            srle_pkg::CSR_SPRITE_HEIGHT: height_ff <= csr_wdata;
         endcase
      end
   end

   always_comb begin
      w_eff = width_ff;
      if (width_ff == 8'd0) begin
         w_eff = 8'd1;
      end else if (width_ff > 8'(srle_pkg::MAX_WIDTH)) begin
         w_eff = 8'(srle_pkg::MAX_WIDTH);
      end
      h_eff = (height_ff == 8'd0) ? 8'd1 : height_ff;
   end

   assign put_pix   = (state_ff == srle_pkg::S_IDLE) ? in_pixel : pix_ff;
   assign row_end   = (9'(col_ff) + 9'd1) >= 9'(w_eff);
   assign image_end = (9'(row_ff) + 9'd1) >= 9'(h_eff);
   assign in_kind   = ~in_pixel[2];
   assign pix_kind  = ~pix_ff[2];
   assign in_ready  = state_ff == srle_pkg::S_IDLE;

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      mode_in    = mode_ff;
      len_in     = len_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      idx_in     = idx_ff;
      pix_in     = pix_ff;
      do_put     = 1'b0;
      close_done = 1'b0;
      pack_req   = '0;
      ram_raddr  = idx_ff;

      unique case (state_ff)
         srle_pkg::S_IDLE: begin
            if (in_valid) begin
               pix_in = in_pixel;
               if (in_kind != mode_ff || len_ff >= srle_pkg::RUN_CAP) begin
                  phase_in = srle_pkg::PH_KIND;
                  state_in = srle_pkg::S_CNT;
               end else begin
                  do_put = 1'b1;
               end
            end
         end
         srle_pkg::S_CNT: begin
            pack_req.step = 1'b1;
            pack_req.wide = 1'b1;
            pack_req.bits = len_ff;
            ram_raddr     = '0;
            if (!(mode_ff && len_ff != 8'd0)) begin
               pack_req.last = phase_ff == srle_pkg::PH_ROW && image_end;
            end
            if (slot_free) begin
               if (mode_ff && len_ff != 8'd0) begin
                  idx_in   = '0;
                  state_in = srle_pkg::S_COL;
               end else begin
                  close_done = 1'b1;
               end
            end
         end
         srle_pkg::S_COL: begin
            pack_req.step = 1'b1;
            pack_req.bits = {6'd0, ram_rdata};
            if ((9'(idx_ff) + 9'd1) == 9'(len_ff)) begin
               pack_req.last = phase_ff == srle_pkg::PH_ROW && image_end;
            end
            // Keep the read one entry ahead of the packer.
            ram_raddr = slot_free ? AW'(9'(idx_ff) + 9'd1) : idx_ff;
            if (slot_free) begin
               if ((9'(idx_ff) + 9'd1) == 9'(len_ff)) begin
                  close_done = 1'b1;
               end else begin
                  idx_in = AW'(9'(idx_ff) + 9'd1);
               end
            end
         end
         srle_pkg::S_GAP: begin
            // Empty run of the other kind after a capped run.
            pack_req.step = 1'b1;
            pack_req.wide = 1'b1;
            if (slot_free) begin
               mode_in  = ~mode_ff;
               state_in = srle_pkg::S_PUT;
            end
         end
         srle_pkg::S_PUT: begin
            do_put   = 1'b1;
            state_in = srle_pkg::S_IDLE;
         end
         srle_pkg::S_FLUSH: begin
            pack_req.step  = 1'b1;
            pack_req.flush = 1'b1;
            if (slot_free) begin
               row_in   = '0;
               state_in = srle_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = srle_pkg::S_IDLE;
         end
      endcase

      if (close_done) begin
         len_in = '0;
         if (phase_ff == srle_pkg::PH_KIND) begin
            mode_in  = ~mode_ff;
            state_in = (pix_kind == mode_ff) ? srle_pkg::S_GAP : srle_pkg::S_PUT;
         end else begin
            mode_in = 1'b0;
            col_in  = '0;
            if (image_end) begin
               state_in = srle_pkg::S_FLUSH;
            end else begin
               row_in   = row_ff + 8'd1;
               state_in = srle_pkg::S_IDLE;
            end
         end
      end

      if (do_put) begin
         len_in = len_ff + 8'd1;
         if (row_end) begin
            phase_in = srle_pkg::PH_ROW;
            state_in = srle_pkg::S_CNT;
         end else begin
            col_in = col_ff + 8'd1;
         end
      end
   end

   assign ram_we    = do_put && mode_ff && (len_ff < 8'(srle_pkg::MAX_WIDTH));
   assign ram_waddr = len_ff[AW-1:0];
   assign ram_wdata = put_pix[1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srle_pkg::S_IDLE;
         phase_ff <= srle_pkg::PH_KIND;
         mode_ff  <= 1'b0;
         len_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
         len_ff   <= len_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

endmodule
